/* rtl/ppc_pkg.sv */
// Shared widths, codes and state type of the pulse peak centroid unit.
// Depends on nothing; every module of the block but ppc_ram imports it.
`timescale 1ns / 1ps
package ppc_pkg;

	localparam int SAMPLES  = 32;                 // samples in one event
	localparam int IW       = $clog2(SAMPLES);    // sample position width
	localparam int RAWW     = 16;                 // raw ADC word width
	localparam int SW       = 10;                 // reduced sample width
	localparam int WW       = 12;                 // outer weight width
	localparam int PIW      = 5;                  // peak_index port width
	localparam int CQW      = 13;                 // centroid width (Q8)
	localparam int STW      = 2;                  // status width
	localparam int DWW      = WW + SW + 2;        // weighted denominator width
	localparam int NUMW     = IW + DWW + 1;       // numerator width
	localparam int DVW      = NUMW + 8;           // dividend width (numerator times 256)
	localparam int MBU      = (WW > IW) ? WW : IW; // unsigned multiplier operand width
	localparam int MA       = DWW + 1;            // signed multiplier operand width
	localparam int PW       = MA + MBU + 1;       // multiply-add result width

	localparam logic [WW-1:0] OUTER_WEIGHT_RESET = WW'(538);

	typedef enum logic [STW-1:0] {
		STAT_OK   = 2'd0,
		STAT_EDGE = 2'd1,
		STAT_ZERO = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		ST_COLLECT,
		ST_CHECK,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_SUM,
		ST_MUL_NP,
		ST_DIV_P,
		ST_WAIT_P,
		ST_MUL_T,
		ST_MUL_NW,
		ST_DIV_W,
		ST_WAIT_W,
		ST_DONE
	} ctrl_state_t;

endpackage

/* rtl/ppc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module ppc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/ppc_mac.sv */
// Shared multiply-add unit: signed a times unsigned b plus signed c, registered.
// Depends on ppc_pkg for operand widths.
`timescale 1ns / 1ps
module ppc_mac (
	input  logic                        clk,
	input  logic signed [ppc_pkg::MA-1:0] a,
	input  logic [ppc_pkg::MBU-1:0]     b,
	input  logic signed [ppc_pkg::PW-1:0] c,
	output logic signed [ppc_pkg::PW-1:0] p_q
);
	import ppc_pkg::*;

	logic signed [MBU:0] b_s;

	assign b_s = $signed({1'b0, b});

	always_ff @(posedge clk) begin
		p_q <= PW'(a * b_s) + c;
	end

endmodule

/* rtl/ppc_div.sv */
// Iterative restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on ppc_pkg for dividend, divisor and quotient widths.
`timescale 1ns / 1ps
module ppc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [ppc_pkg::DVW-1:0] num,
	input  logic [ppc_pkg::DWW-1:0] den,
	output logic                  done,
	output logic [ppc_pkg::CQW-1:0] quo
);
	import ppc_pkg::*;

	localparam int CNTW = $clog2(CQW);

	logic             busy_q;
	logic             done_q;
	logic [CNTW-1:0]  cnt_q;
	logic [DWW:0]     rem_q;
	logic [CQW-1:0]   low_q;
	logic [CQW-1:0]   quo_q;
	logic [DWW-1:0]   den_q;
	logic [DWW:0]     trial;
	logic             fits;
	logic             ovf;

	// The quotient would not fit when the dividend reaches den * 2^CQW.
	assign ovf   = ({1'b0, num} >= ((DVW+1)'(den) << CQW));
	assign trial = {rem_q[DWW-1:0], low_q[CQW-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= !ovf;
				done_q <= ovf;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(CQW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			den_q <= den;
			rem_q <= (DWW+1)'(num >> CQW);
			low_q <= num[CQW-1:0];
			quo_q <= ovf ? {CQW{1'b1}} : '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			low_q <= {low_q[CQW-2:0], 1'b0};
			quo_q <= {quo_q[CQW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/pulse_peak_centroid_unit.sv */
// Top level of the pulse peak centroid unit: sample capture, peak tracking and sequencer.
// Depends on ppc_pkg, ppc_ram, ppc_mac and ppc_div.
`timescale 1ns / 1ps
// How to use this block:
// Each event is SAMPLES raw ADC words. A word is taken as one beat at a rising edge where
// start is high and busy is low; bits 11..2 of raw_word form the 10-bit sample that is
// stored and compared against the running peak. While an event is being collected busy
// stays low, so one word can be taken every cycle.
// After the last word of an event busy rises and a small sequencer works out the result.
// It reads the peak and its two neighbors from the sample RAM, adds up the plain sums,
// forms the weighted sum and the numerators with one shared multiply-add unit, and runs
// both divisions through one shared restoring divider that yields one quotient bit per
// cycle. An edge peak goes from ST_CHECK straight to ST_DONE; a full computation also
// runs the reads, the multiply-adds and the two 13-step divisions.
// The result beat appears for exactly one cycle with done high; the receiver cannot
// stall it, so it must take the beat in that cycle. busy falls in the cycle after.
// The outer weight register is written over the cfg channel, which is always ready; it
// should only be written while no event is in flight.
// Reset clears the sample counter, the peak tracker and the sequencer and loads the
// outer weight with its default of 538 (about 2.1 in Q8). The sample RAM is not cleared:
// only entries of the current event are ever read.
module pulse_peak_centroid_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [ppc_pkg::RAWW-1:0] raw_word,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [ppc_pkg::WW-1:0]  cfg_data,
	output logic                    done,
	output logic [ppc_pkg::SW-1:0]  peak_value,
	output logic [ppc_pkg::PIW-1:0] peak_index,
	output logic [ppc_pkg::CQW-1:0] centroid_q8,
	output logic [ppc_pkg::CQW-1:0] weighted_centroid_q8,
	output logic [ppc_pkg::STW-1:0] status
);
	import ppc_pkg::*;

	ctrl_state_t state_q, state_d;

	// Configuration and event collection.
	logic [WW-1:0]  w_q;
	logic [IW-1:0]  count_q;
	logic [SW-1:0]  peak_q;
	logic [IW-1:0]  place_q;
	logic [SW-1:0]  sample;
	logic           accept;
	logic           last;

	// Neighborhood values and intermediate results.
	logic [SW-1:0]        f1_q;
	logic [SW-1:0]        f2_q;
	logic [SW+1:0]        den_p_q;
	logic [SW:0]          s13_q;
	logic signed [SW:0]   diff_q;
	logic [DWW-1:0]       den_w_q;
	logic [CQW-1:0]       cp_q;
	logic [CQW-1:0]       cw_q;
	stat_t                status_q;
	logic                 edge_peak;

	// Shared unit interfaces.
	logic [IW-1:0]          raddr;
	logic [SW-1:0]          rdata;
	logic signed [MA-1:0]   mac_a;
	logic [MBU-1:0]         mac_b;
	logic signed [PW-1:0]   mac_c;
	logic signed [PW-1:0]   mac_q;
	logic                   div_go;
	logic [DVW-1:0]         div_num;
	logic [DWW-1:0]         div_den;
	logic                   div_done;
	logic [CQW-1:0]         div_quo;

	assign sample    = raw_word[11:2];
	assign busy      = (state_q != ST_COLLECT);
	assign accept    = start && !busy;
	assign last      = (count_q == IW'(SAMPLES - 1));
	assign cfg_ready = 1'b1;
	assign edge_peak = (place_q == '0) || (place_q == IW'(SAMPLES - 1));

	// The configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= OUTER_WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			w_q <= cfg_data;
		end
	end

	// Sample counter and first-maximum tracker. The first sample of an event restarts
	// the peak, and a later sample only wins when it is strictly larger.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			peak_q  <= '0;
			place_q <= '0;
		end else if (accept) begin
			count_q <= last ? '0 : count_q + IW'(1);
			if (count_q == '0) begin
				peak_q  <= sample;
				place_q <= '0;
			end else if (sample > peak_q) begin
				peak_q  <= sample;
				place_q <= count_q;
			end
		end
	end

	ppc_ram #(
		.WIDTH (SW),
		.DEPTH (SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (count_q),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	ppc_mac u_mac (
		.clk (clk),
		.a   (mac_a),
		.b   (mac_b),
		.c   (mac_c),
		.p_q (mac_q)
	);

	ppc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (accept && last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:  state_d = edge_peak ? ST_DONE : ST_RD0;
			ST_RD0:    state_d = ST_RD1;
			ST_RD1:    state_d = ST_RD2;
			ST_RD2:    state_d = ST_RD3;
			ST_RD3:    state_d = ST_SUM;
			ST_SUM:    state_d = (den_p_q == '0) ? ST_DONE : ST_MUL_NP;
			ST_MUL_NP: state_d = ST_DIV_P;
			ST_DIV_P:  state_d = ST_WAIT_P;
			ST_WAIT_P: begin
				if (div_done) begin
					state_d = (den_w_q == '0) ? ST_DONE : ST_MUL_T;
				end
			end
			ST_MUL_T:  state_d = ST_MUL_NW;
			ST_MUL_NW: state_d = ST_DIV_W;
			ST_DIV_W:  state_d = ST_WAIT_W;
			ST_WAIT_W: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:   state_d = ST_COLLECT;
			default:   state_d = ST_COLLECT;
		endcase
	end

	// Operand selection for the RAM read port, the multiply-add unit and the divider.
	// Plain:    den = f1+f2+f3,            num = p*den + (f3-f1)
	// Weighted: den = w*(f1+f3) + 256*f2,  num = p*den + w*(f3-f1)
	always_comb begin
		raddr   = place_q;
		mac_a   = '0;
		mac_b   = '0;
		mac_c   = '0;
		div_go  = 1'b0;
		div_num = {NUMW'(mac_q), 8'd0};
		div_den = DWW'(den_p_q);
		unique case (state_q)
			ST_RD0: raddr = place_q - IW'(1);
			ST_RD1: raddr = place_q;
			ST_RD2: raddr = place_q + IW'(1);
			ST_SUM: begin
				mac_a = $signed(MA'(s13_q));
				mac_b = MBU'(w_q);
				mac_c = $signed(PW'({f2_q, 8'd0}));
			end
			ST_MUL_NP: begin
				mac_a = $signed(MA'(den_p_q));
				mac_b = MBU'(place_q);
				mac_c = PW'(diff_q);
			end
			ST_DIV_P: begin
				div_go  = 1'b1;
				div_den = DWW'(den_p_q);
			end
			ST_MUL_T: begin
				mac_a = MA'(diff_q);
				mac_b = MBU'(w_q);
			end
			ST_MUL_NW: begin
				mac_a = $signed(MA'(den_w_q));
				mac_b = MBU'(place_q);
				mac_c = mac_q;
			end
			ST_DIV_W: begin
				div_go  = 1'b1;
				div_den = den_w_q;
			end
			default: begin
				raddr = place_q;
			end
		endcase
	end

	// Datapath registers written step by step.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CHECK: begin
				status_q <= edge_peak ? STAT_EDGE : STAT_OK;
				cp_q     <= '0;
				cw_q     <= '0;
			end
			ST_RD1: f1_q <= rdata;
			ST_RD2: f2_q <= rdata;
			ST_RD3: begin
				den_p_q <= (SW+2)'(f1_q) + (SW+2)'(f2_q) + (SW+2)'(rdata);
				s13_q   <= (SW+1)'(f1_q) + (SW+1)'(rdata);
				diff_q  <= $signed((SW+1)'(rdata)) - $signed((SW+1)'(f1_q));
			end
			ST_SUM: begin
				if (den_p_q == '0) begin
					status_q <= STAT_ZERO;
				end
			end
			ST_MUL_NP: den_w_q <= DWW'(mac_q);
			ST_WAIT_P: begin
				if (div_done) begin
					// A zero weighted denominator voids the plain centroid as well.
					if (den_w_q == '0) begin
						status_q <= STAT_ZERO;
					end else begin
						cp_q <= div_quo;
					end
				end
			end
			ST_WAIT_W: begin
				if (div_done) begin
					cw_q <= div_quo;
				end
			end
			default: begin
				f1_q <= f1_q;
			end
		endcase
	end

	assign done                 = (state_q == ST_DONE);
	assign peak_value           = peak_q;
	assign peak_index           = PIW'(place_q);
	assign centroid_q8          = cp_q;
	assign weighted_centroid_q8 = cw_q;
	assign status               = status_q;

endmodule

/* tb/ppc_centroid_checker.sv */
// Checker for the pulse peak centroid unit: tracks the sample, config and result beats,
// predicts each event's peak and centroids, and compares every result beat against them.
// Depends on ppc_pkg for widths and the status codes.
`timescale 1ns / 1ps
module ppc_centroid_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [ppc_pkg::RAWW-1:0] raw_word,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [ppc_pkg::WW-1:0]   cfg_data,
	input  logic                     done,
	input  logic [ppc_pkg::SW-1:0]   peak_value,
	input  logic [ppc_pkg::PIW-1:0]  peak_index,
	input  logic [ppc_pkg::CQW-1:0]  centroid_q8,
	input  logic [ppc_pkg::CQW-1:0]  weighted_centroid_q8,
	input  logic [ppc_pkg::STW-1:0]  status,
	output int                       fail_count,
	output int                       pending,
	output int                       events_seen,
	output int                       edge_events
);
	import ppc_pkg::*;

	localparam longint unsigned CENT_MAX = (64'd1 << CQW) - 1;

	typedef struct {
		logic [SW-1:0]  peak;
		logic [PIW-1:0] idx;
		logic [CQW-1:0] cent;
		logic [CQW-1:0] wcent;
		stat_t          st;
	} pulse_result_t;

	pulse_result_t  results_due[$];
	logic [WW-1:0]  weight;
	logic [SW-1:0]  store [SAMPLES];
	logic [SW-1:0]  top_value;
	int             top_place;
	int             fill;
	int             errors;
	int             n_events;
	int             n_edge;

	function automatic logic [CQW-1:0] q8_quotient(longint unsigned num, longint unsigned den);
		longint unsigned q;
		q = (num * 256) / den;
		return (q > CENT_MAX) ? CQW'(CENT_MAX) : CQW'(q);
	endfunction

	// Folds one accepted word into the event; the last word of an event queues its result.
	task automatic fold_sample(input logic [RAWW-1:0] w);
		logic [SW-1:0]   s;
		pulse_result_t   r;
		longint unsigned f1, f2, f3, wt, num, den;
		int              p;
		s = w[11:2];
		if (fill == 0) begin
			top_value = '0;
			top_place = 0;
		end
		store[fill] = s;
		if (s > top_value) begin
			top_value = s;
			top_place = fill;
		end
		fill++;
		if (fill < SAMPLES)
			return;
		fill = 0;
		p = top_place;
		r.peak = top_value;
		r.idx = PIW'(p);
		r.cent = '0;
		r.wcent = '0;
		r.st = STAT_OK;
		if (p == 0 || p + 1 >= SAMPLES) begin
			r.st = STAT_EDGE;
		end else begin
			f1 = store[p-1];
			f2 = store[p];
			f3 = store[p+1];
			den = f1 + f2 + f3;
			if (den == 0) begin
				r.st = STAT_ZERO;
			end else begin
				num = f1 * (p - 1) + f2 * p + f3 * (p + 1);
				r.cent = q8_quotient(num, den);
				wt = weight;
				den = wt * f1 + 256 * f2 + wt * f3;
				if (den == 0) begin
					r.st = STAT_ZERO;
					r.cent = '0;
				end else begin
					num = wt * f1 * (p - 1) + 256 * f2 * p + wt * f3 * (p + 1);
					r.wcent = q8_quotient(num, den);
				end
			end
		end
		results_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pulse_result_t oldest;
		if (!arst_n) begin
			results_due.delete();
			weight = OUTER_WEIGHT_RESET;
			fill = 0;
			top_value = '0;
			top_place = 0;
			errors = 0;
			n_events = 0;
			n_edge = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				weight = cfg_data;
			if (done) begin
				if (results_due.size() == 0) begin
					$error("result beat with no event waiting for it");
					errors++;
				end else begin
					oldest = results_due.pop_front();
					n_events++;
					if (oldest.st == STAT_EDGE)
						n_edge++;
					if (peak_value !== oldest.peak) begin
						$error("peak_value: expected %0d, got %0d", oldest.peak, peak_value);
						errors++;
					end
					if (peak_index !== oldest.idx) begin
						$error("peak_index: expected %0d, got %0d", oldest.idx, peak_index);
						errors++;
					end
					if (centroid_q8 !== oldest.cent) begin
						$error("centroid_q8: expected %0d, got %0d", oldest.cent, centroid_q8);
						errors++;
					end
					if (weighted_centroid_q8 !== oldest.wcent) begin
						$error("weighted_centroid_q8: expected %0d, got %0d", oldest.wcent,
							weighted_centroid_q8);
						errors++;
					end
					if (status !== oldest.st) begin
						$error("status: expected %0d, got %0d", oldest.st, status);
						errors++;
					end
				end
			end
			if (start && !busy)
				fold_sample(raw_word);
		end
		fail_count <= errors;
		pending <= results_due.size();
		events_seen <= n_events;
		edge_events <= n_edge;
	end

endmodule

/* tb/tb.sv */
// Top of the pulse peak centroid testbench: clock, reset, sample and config stimulus,
// watchdog and verdict. Depends on ppc_pkg, the unit under test and ppc_centroid_checker.
`timescale 1ns / 1ps
module tb;
	import ppc_pkg::*;

	// The limit lies far beyond a full computation after the last word, so a quiet stretch of
	// this length can only mean the block has hung.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int EVENTS_PER_PHASE = 3;
	localparam int PHASES = 6;
	// The phase that runs without idling plays more events, for one long busy stretch.
	localparam int NO_IDLE_PHASE = 3;
	localparam int NO_IDLE_EVENTS = 6;
	// Cycles allowed for the sequencer to settle before a config write and at the end.
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 50;

	// Ways of filling the bits of raw_word that the block throws away.
	localparam int OUTER_ZERO = 0;
	localparam int OUTER_ONES = 1;
	localparam int OUTER_RAND = 2;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [RAWW-1:0]  raw_word = '0;
	logic             cfg_valid = 1'b0;
	logic [WW-1:0]    cfg_data = '0;
	logic             busy;
	logic             cfg_ready;
	logic             done;
	logic [SW-1:0]    peak_value;
	logic [PIW-1:0]   peak_index;
	logic [CQW-1:0]   centroid_q8;
	logic [CQW-1:0]   weighted_centroid_q8;
	logic [STW-1:0]   status;

	int fail_count;
	int pending;
	int events_seen;
	int edge_events;

	int idle_pct = 24;
	int words_sent = 0;
	int weight_writes = 0;
	int quiet_cycles = 0;

	// The event being played: one 10-bit sample per position.
	logic [SW-1:0] shape [SAMPLES];
	logic [WW-1:0] phase_weight [PHASES];

	pulse_peak_centroid_unit uut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.raw_word             (raw_word),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_data             (cfg_data),
		.done                 (done),
		.peak_value           (peak_value),
		.peak_index           (peak_index),
		.centroid_q8          (centroid_q8),
		.weighted_centroid_q8 (weighted_centroid_q8),
		.status               (status)
	);

	ppc_centroid_checker chk (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.raw_word             (raw_word),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_data             (cfg_data),
		.done                 (done),
		.peak_value           (peak_value),
		.peak_index           (peak_index),
		.centroid_q8          (centroid_q8),
		.weighted_centroid_q8 (weighted_centroid_q8),
		.status               (status),
		.fail_count           (fail_count),
		.pending              (pending),
		.events_seen          (events_seen),
		.edge_events          (edge_events)
	);

	always #10 clk = ~clk;

	// Any accepted beat on any channel counts as progress; a long run without one is a hang.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Sends one raw word as a beat. The task is entered and left just after a rising edge.
	// Before the word the sender may idle a few cycles with start low and junk on the bus.
	// Once start is up it stays up until the beat is taken, which also holds it through
	// the whole computation when the word opens the next event.
	task automatic send_word(input logic [RAWW-1:0] w);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			raw_word <= RAWW'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		raw_word <= w;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	// Plays the current shape as one event. The bits that the block drops are filled as
	// asked, so both the masking and the full range of raw_word get exercised.
	task automatic play_shape(input int outer);
		logic [3:0] hi;
		logic [1:0] lo;
		for (int i = 0; i < SAMPLES; i++) begin
			case (outer)
				OUTER_ZERO: begin
					hi = '0;
					lo = '0;
				end
				OUTER_ONES: begin
					hi = '1;
					lo = '1;
				end
				default: begin
					hi = 4'($urandom);
					lo = 2'($urandom);
				end
			endcase
			send_word({hi, shape[i], lo});
		end
	endtask

	task automatic fill_shape(input logic [SW-1:0] v);
		for (int i = 0; i < SAMPLES; i++)
			shape[i] = v;
	endtask

	// One random event. Most are pulses with a clear interior peak, which reach the division
	// path; the rest are noise, edge peaks, flat lines and lone spikes.
	task automatic play_random_event;
		int kind;
		int amp;
		int p;
		kind = $urandom_range(9, 0);
		amp = $urandom_range(1023, 1);
		p = $urandom_range(SAMPLES - 2, 1);
		for (int i = 0; i < SAMPLES; i++)
			shape[i] = SW'($urandom_range(amp / 4, 0));
		case (kind)
			6: begin
				for (int i = 0; i < SAMPLES; i++)
					shape[i] = SW'($urandom);
			end
			7: begin
				p = $urandom_range(1, 0) ? 0 : SAMPLES - 1;
				shape[p] = SW'(amp);
			end
			8: fill_shape($urandom_range(1, 0) ? '0 : SW'($urandom));
			9: begin
				fill_shape('0);
				shape[p] = SW'(amp);
			end
			default: begin
				shape[p] = SW'(amp);
				shape[p-1] = SW'($urandom_range(amp, 0));
				shape[p+1] = SW'($urandom_range(amp, 0));
			end
		endcase
		play_shape(OUTER_RAND);
	endtask

	// Holds the sender off until every queued result has been checked and the sequencer
	// has dropped busy, then gives it a few more cycles to settle.
	task automatic wait_quiet;
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_weight(input logic [WW-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		weight_writes++;
	endtask

	initial begin
		phase_weight[0] = '0;
		phase_weight[1] = '1;
		phase_weight[2] = WW'(1);
		phase_weight[3] = WW'(256);
		phase_weight[4] = WW'($urandom);
		phase_weight[5] = OUTER_WEIGHT_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events, all under the reset value of the outer weight.
		// An all-zero event: every word is zero, the peak stays at position 0.
		fill_shape('0);
		play_shape(OUTER_ZERO);
		// A flat line at full scale from all-ones words: the first maximum wins.
		fill_shape('1);
		play_shape(OUTER_ONES);
		// Zero samples with every dropped bit set, to show they are masked off.
		fill_shape('0);
		play_shape(OUTER_ONES);
		// A rising ramp, so the peak sits on the last sample.
		for (int i = 0; i < SAMPLES; i++)
			shape[i] = SW'(i * 33);
		play_shape(OUTER_RAND);
		// Peak on the first interior position, tied with its right neighbor.
		fill_shape('0);
		shape[0] = SW'(500);
		shape[1] = '1;
		shape[2] = '1;
		play_shape(OUTER_RAND);
		// Peak on the last interior position.
		fill_shape(SW'(3));
		shape[SAMPLES-3] = SW'(10);
		shape[SAMPLES-2] = SW'(800);
		shape[SAMPLES-1] = SW'(799);
		play_shape(OUTER_RAND);
		// A lone spike with zero neighbors lands exactly on its own position.
		fill_shape('0);
		shape[16] = SW'(700);
		play_shape(OUTER_RAND);
		// Full-scale peak with near-full neighbors: the largest sums and products.
		fill_shape(SW'(100));
		shape[14] = SW'(1022);
		shape[15] = '1;
		shape[16] = SW'(1022);
		play_shape(OUTER_RAND);
		// The smallest possible interior peak.
		fill_shape('0);
		shape[7] = SW'(1);
		play_shape(OUTER_RAND);

		// Random events in phases, each under its own outer weight. The weight is only
		// written once the block has gone idle. One phase runs without any idling.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_quiet();
			write_weight(phase_weight[ph]);
			idle_pct = (ph == NO_IDLE_PHASE) ? 0 : 24;
			for (int e = 0;
				e < ((ph == NO_IDLE_PHASE) ? NO_IDLE_EVENTS : EVENTS_PER_PHASE); e++)
				play_random_event();
		end

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d words in %0d events, %0d of them with the peak at an edge.",
			words_sent, events_seen, edge_events);
		$display("Outer weight was written %0d times, spanning 0 to 4095.", weight_writes);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
